/* rtl/vrs_pkg.sv */
// Package for the vector reduction statistics block.
// Holds field widths, payload types and state encodings; used by every rtl file but vrs_sub.
package vrs_pkg;

  // Fixed payload widths
  localparam int ELEM_W      = 16;
  localparam int IDX_W       = 10;
  localparam int NORM_W      = 21;
  localparam int MAX_LEN_DEF = 1024;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic        [IDX_W-1:0]  idx_t;
  typedef logic        [NORM_W-1:0] norm_t;

  // Top level sequencer
  typedef enum logic [1:0] {
    ST_ACC,
    ST_START,
    ST_CALC,
    ST_LOAD
  } top_state_t;

  // Divide / square root sequencer
  typedef enum logic [2:0] {
    IT_IDLE,
    IT_DIV,
    IT_MEAN,
    IT_SQRT,
    IT_DONE
  } iter_state_t;

endpackage

/* rtl/vrs_sub.sv */
// Shared subtract and compare unit for the divide and square root steps.
// Depends on nothing.
module vrs_sub #(
  parameter int W = 16
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  // One wide subtract; the borrow gives the compare
  logic [W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[W-1:0];
  assign ge   = ~full[W];

endmodule

/* rtl/vrs_accum.sv */
// Running statistics over one vector: sum, sum of squares, extremes and positions.
// Depends on vrs_pkg.
module vrs_accum #(
  parameter int MAX_LEN = vrs_pkg::MAX_LEN_DEF,
  parameter int CW      = 11,
  parameter int SW      = 27,
  parameter int SQW     = 43
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  vrs_pkg::elem_t       elem,
  input  logic                 clear,
  output logic signed [SW-1:0] sum,
  output logic [SQW-1:0]       sqsum,
  output logic [CW-1:0]        count,
  output vrs_pkg::elem_t       min_val,
  output vrs_pkg::elem_t       max_val,
  output logic [CW-1:0]        min_pos,
  output logic [CW-1:0]        max_pos,
  output logic                 ovf
);

  localparam int          SQ_W = 2 * vrs_pkg::ELEM_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_LEN);

  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [SQW-1:0]       sqsum_r, sqsum_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  vrs_pkg::elem_t       min_r, min_nxt, max_r, max_nxt;
  logic [CW-1:0]        minp_r, minp_nxt, maxp_r, maxp_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [SQ_W-1:0]      sq_r, sq_nxt;
  logic                 sqv_r, sqv_nxt;

  // Update rules; the square is registered and added to the sum of squares in the following cycle
  always_comb begin
    sum_nxt   = sum_r;
    sqsum_nxt = sqsum_r;
    cnt_nxt   = cnt_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    minp_nxt  = minp_r;
    maxp_nxt  = maxp_r;
    ovf_nxt   = ovf_r;
    sq_nxt    = sq_r;
    sqv_nxt   = 1'b0;
    if (sqv_r) begin
      sqsum_nxt = sqsum_r + SQW'(sq_r);
    end
    if (clear) begin
      sum_nxt   = '0;
      sqsum_nxt = '0;
      cnt_nxt   = '0;
      min_nxt   = '0;
      max_nxt   = '0;
      minp_nxt  = '0;
      maxp_nxt  = '0;
      ovf_nxt   = 1'b0;
    end else if (take) begin
      if (cnt_r == FULL_CNT) begin
        ovf_nxt = 1'b1;
      end else begin
        sum_nxt = sum_r + SW'(elem);
        // full-width signed product, always non-negative
        sq_nxt  = $unsigned(SQ_W'(elem) * SQ_W'(elem));
        sqv_nxt = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '0) begin
          min_nxt  = elem;
          max_nxt  = elem;
          minp_nxt = '0;
          maxp_nxt = '0;
        end else begin
          if (elem < min_r) begin
            min_nxt  = elem;
            minp_nxt = cnt_r;
          end
          if (elem > max_r) begin
            max_nxt  = elem;
            maxp_nxt = cnt_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      sqsum_r <= '0;
      cnt_r   <= '0;
      min_r   <= '0;
      max_r   <= '0;
      minp_r  <= '0;
      maxp_r  <= '0;
      ovf_r   <= 1'b0;
      sqv_r   <= 1'b0;
    end else begin
      sum_r   <= sum_nxt;
      sqsum_r <= sqsum_nxt;
      cnt_r   <= cnt_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      minp_r  <= minp_nxt;
      maxp_r  <= maxp_nxt;
      ovf_r   <= ovf_nxt;
      sqv_r   <= sqv_nxt;
    end
  end

  // Square product register, payload only
  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
  end

  assign sum     = sum_r;
  assign sqsum   = sqsum_r;
  assign count   = cnt_r;
  assign min_val = min_r;
  assign max_val = max_r;
  assign min_pos = minp_r;
  assign max_pos = maxp_r;
  assign ovf     = ovf_r;

endmodule

/* rtl/vrs_iter.sv */
// Iterative mean divider and integer square root over one shared subtractor.
// Depends on vrs_pkg and vrs_sub.
module vrs_iter #(
  parameter int CW  = 11,
  parameter int SW  = 27,
  parameter int SQW = 43
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [SW-1:0] sum,
  input  logic [CW-1:0]        count,
  input  logic [SQW-1:0]       sqsum,
  output logic                 done,
  output vrs_pkg::elem_t       mean,
  output vrs_pkg::norm_t       norm
);

  localparam int RW  = (SQW + 1) / 2;
  localparam int AW  = (SW > RW) ? SW : RW;
  localparam int OW  = (SW > 2 * RW) ? SW : 2 * RW;
  localparam int UW  = (CW + 1 > RW + 3) ? CW + 1 : RW + 3;
  localparam int STW = $clog2(AW);
  localparam logic [STW-1:0] DIV_LAST  = STW'(SW - 1);
  localparam logic [STW-1:0] SQRT_LAST = STW'(RW - 1);

  vrs_pkg::iter_state_t state_r, state_nxt;
  logic [UW-1:0]  rem_r, rem_nxt;
  logic [AW-1:0]  acc_r, acc_nxt;
  logic [OW-1:0]  opd_r, opd_nxt;
  logic [STW-1:0] step_r, step_nxt;
  logic           neg_r, neg_nxt;
  vrs_pkg::elem_t mean_r, mean_nxt;

  logic [UW-1:0]  sub_a, sub_b, sub_diff;
  logic           sub_ge;
  logic [SW-1:0]  mag, quo, quo_neg;

  vrs_sub #(.W(UW)) u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  assign mag     = sum[SW-1] ? -sum : sum;
  assign quo     = acc_r[SW-1:0];
  assign quo_neg = -quo;

  // Operand select: restoring divide takes one dividend bit, root takes two
  always_comb begin
    if (state_r == vrs_pkg::IT_SQRT) begin
      sub_a = UW'({rem_r, opd_r[2*RW-1 -: 2]});
      sub_b = UW'({acc_r, 2'b01});
    end else begin
      sub_a = UW'({rem_r, opd_r[SW-1]});
      sub_b = UW'(count);
    end
  end

  // Sequencer and datapath next values
  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    opd_nxt   = opd_r;
    step_nxt  = step_r;
    neg_nxt   = neg_r;
    mean_nxt  = mean_r;
    done      = 1'b0;
    unique case (state_r)
      vrs_pkg::IT_IDLE: begin
        if (start) begin
          neg_nxt   = sum[SW-1];
          opd_nxt   = OW'(mag);
          rem_nxt   = '0;
          acc_nxt   = '0;
          step_nxt  = '0;
          state_nxt = vrs_pkg::IT_DIV;
        end
      end
      vrs_pkg::IT_DIV: begin
        rem_nxt  = sub_ge ? sub_diff : sub_a;
        acc_nxt  = {acc_r[AW-2:0], sub_ge};
        opd_nxt  = opd_r << 1;
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          state_nxt = vrs_pkg::IT_MEAN;
        end
      end
      vrs_pkg::IT_MEAN: begin
        // Zero count guard; then load the root operand
        if (count == '0) begin
          mean_nxt = '0;
        end else begin
          mean_nxt = vrs_pkg::elem_t'(neg_r ? quo_neg : quo);
        end
        opd_nxt   = OW'(sqsum);
        rem_nxt   = '0;
        acc_nxt   = '0;
        step_nxt  = '0;
        state_nxt = vrs_pkg::IT_SQRT;
      end
      vrs_pkg::IT_SQRT: begin
        rem_nxt  = sub_ge ? sub_diff : sub_a;
        acc_nxt  = {acc_r[AW-2:0], sub_ge};
        opd_nxt  = opd_r << 2;
        step_nxt = step_r + 1'b1;
        if (step_r == SQRT_LAST) begin
          state_nxt = vrs_pkg::IT_DONE;
        end
      end
      vrs_pkg::IT_DONE: begin
        done      = 1'b1;
        state_nxt = vrs_pkg::IT_IDLE;
      end
      default: begin
        state_nxt = vrs_pkg::IT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vrs_pkg::IT_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Working registers, payload only
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
    opd_r  <= opd_nxt;
    neg_r  <= neg_nxt;
    mean_r <= mean_nxt;
  end

  assign mean = mean_r;
  assign norm = vrs_pkg::norm_t'(acc_r);

endmodule

/* rtl/vector_reduction_stats_top.sv */
// Top level of the vector reduction statistics block: handshakes and result register.
// Depends on vrs_pkg, vrs_accum and vrs_iter.
//
//  channel | ports                                               | moves
//  --------+-----------------------------------------------------+---------------------------
//  in      | in_valid, in_ready, in_element, in_last             | one vector element a word
//  out     | out_valid, out_ready, out_min_value ... out_overflow | one result word per vector
//
// Elements are taken one per cycle while in_ready is high. The closing word starts the
// divide and root on one shared subtractor, with in_ready low throughout: SW = 16 +
// clog2(MAX_LEN+1) divide steps and RW = ceil((32 + clog2(MAX_LEN+1))/2) root
// steps. Reset is synchronous and clears all sums.
// A waiting result does not block the next vector's elements; if it still waits
// when that vector's stats are ready, in_ready stays low until out_ready.
module vector_reduction_stats_top #(
  parameter int MAX_LEN = vrs_pkg::MAX_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  vrs_pkg::elem_t in_element,
  input  logic           in_last,
  output logic           out_valid,
  input  logic           out_ready,
  output vrs_pkg::elem_t out_min_value,
  output vrs_pkg::elem_t out_max_value,
  output vrs_pkg::idx_t  out_min_index,
  output vrs_pkg::idx_t  out_max_index,
  output vrs_pkg::elem_t out_mean_value,
  output vrs_pkg::norm_t out_norm_value,
  output logic           out_overflow
);

  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int SW  = vrs_pkg::ELEM_W + CW;
  localparam int SQW = 2 * vrs_pkg::ELEM_W + CW;

  vrs_pkg::top_state_t state_r, state_nxt;
  logic take, clear, start, load, it_done;

  logic signed [SW-1:0] sum;
  logic [SQW-1:0]       sqsum;
  logic [CW-1:0]        count, min_pos, max_pos;
  vrs_pkg::elem_t       min_val, max_val, mean;
  vrs_pkg::norm_t       norm;
  logic                 ovf;

  logic           ov_r, ov_nxt;
  vrs_pkg::elem_t omin_r, omax_r, omean_r;
  vrs_pkg::idx_t  ominp_r, omaxp_r;
  vrs_pkg::norm_t onorm_r;
  logic           oovf_r;

  assign in_ready = (state_r == vrs_pkg::ST_ACC);
  assign take     = in_valid && in_ready;

  vrs_accum #(
    .MAX_LEN (MAX_LEN),
    .CW      (CW),
    .SW      (SW),
    .SQW     (SQW)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .elem    (in_element),
    .clear   (clear),
    .sum     (sum),
    .sqsum   (sqsum),
    .count   (count),
    .min_val (min_val),
    .max_val (max_val),
    .min_pos (min_pos),
    .max_pos (max_pos),
    .ovf     (ovf)
  );

  vrs_iter #(
    .CW  (CW),
    .SW  (SW),
    .SQW (SQW)
  ) u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sum   (sum),
    .count (count),
    .sqsum (sqsum),
    .done  (it_done),
    .mean  (mean),
    .norm  (norm)
  );

  // Vector sequencer: accumulate, start, wait for the unit, hand off the result
  always_comb begin
    state_nxt = state_r;
    start     = 1'b0;
    load      = 1'b0;
    clear     = 1'b0;
    unique case (state_r)
      vrs_pkg::ST_ACC: begin
        if (take && in_last) begin
          state_nxt = vrs_pkg::ST_START;
        end
      end
      vrs_pkg::ST_START: begin
        start     = 1'b1;
        state_nxt = vrs_pkg::ST_CALC;
      end
      vrs_pkg::ST_CALC: begin
        if (it_done) begin
          state_nxt = vrs_pkg::ST_LOAD;
        end
      end
      vrs_pkg::ST_LOAD: begin
        if (!ov_r || out_ready) begin
          load      = 1'b1;
          clear     = 1'b1;
          state_nxt = vrs_pkg::ST_ACC;
        end
      end
      default: begin
        state_nxt = vrs_pkg::ST_ACC;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vrs_pkg::ST_ACC;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (load) begin
      omin_r  <= min_val;
      omax_r  <= max_val;
      ominp_r <= vrs_pkg::idx_t'(min_pos);
      omaxp_r <= vrs_pkg::idx_t'(max_pos);
      omean_r <= mean;
      onorm_r <= norm;
      oovf_r  <= ovf;
    end
  end

  assign out_valid      = ov_r;
  assign out_min_value  = omin_r;
  assign out_max_value  = omax_r;
  assign out_min_index  = ominp_r;
  assign out_max_index  = omaxp_r;
  assign out_mean_value = omean_r;
  assign out_norm_value = onorm_r;
  assign out_overflow   = oovf_r;

  // The closing word shuts the input until the result is handed off
  a_close_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_last |=> !in_ready)
    else $error("input still open after closing word");

  // A result word appears only out of the hand-off state
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == vrs_pkg::ST_LOAD))
    else $error("result word raised outside hand-off");

  // The shared unit finishes only while the sequencer waits for it
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    it_done |-> state_r == vrs_pkg::ST_CALC)
    else $error("unit finished while not in use");

  // The element count never passes the length limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(MAX_LEN))
    else $error("element count beyond length limit");

endmodule

/* dv/vrs_stats_checker.sv */
// Checker for the vector reduction statistics block: watches both channels,
// predicts each result word and compares it field by field. Depends on vrs_pkg.
module vrs_stats_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  vrs_pkg::elem_t in_element,
  input  logic           in_last,
  input  logic           out_valid,
  input  logic           out_ready,
  input  vrs_pkg::elem_t out_min_value,
  input  vrs_pkg::elem_t out_max_value,
  input  vrs_pkg::idx_t  out_min_index,
  input  vrs_pkg::idx_t  out_max_index,
  input  vrs_pkg::elem_t out_mean_value,
  input  vrs_pkg::norm_t out_norm_value,
  input  logic           out_overflow,
  output int             fail_count,
  output int             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 200;

  typedef struct packed {
    vrs_pkg::elem_t min_v;
    vrs_pkg::elem_t max_v;
    vrs_pkg::idx_t  min_i;
    vrs_pkg::idx_t  max_i;
    vrs_pkg::elem_t mean_v;
    vrs_pkg::norm_t norm_v;
    logic           ovf;
  } stats_word_t;

  // Stats words still owed by the block, oldest first
  stats_word_t stats_due[$];

  // Running state of the vector being collected
  int unsigned     taken;
  longint          run_sum;
  longint unsigned run_sq;
  vrs_pkg::elem_t  lo;
  vrs_pkg::elem_t  hi;
  vrs_pkg::idx_t   lo_at;
  vrs_pkg::idx_t   hi_at;
  logic            spill;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic flag_mismatch(input string what);
    if (fail_count < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    fail_count++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) begin
      flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  task automatic clear_sums();
    taken   = 0;
    run_sum = 0;
    run_sq  = 0;
    lo      = '0;
    hi      = '0;
    lo_at   = '0;
    hi_at   = '0;
    spill   = 1'b0;
  endtask

  // Largest r with r*r <= x, built one result bit at a time
  function automatic vrs_pkg::norm_t floor_root(input longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = vrs_pkg::NORM_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return vrs_pkg::norm_t'(r);
  endfunction

  // Fold one accepted word into the sums; a closing word queues the stats
  task automatic fold_element(input vrs_pkg::elem_t e, input logic closing);
    stats_word_t w;
    longint      mean;
    if (taken >= vrs_pkg::MAX_LEN_DEF) begin
      // past the length limit: ignored, only remembered
      spill = 1'b1;
    end else begin
      run_sum += longint'(e);
      run_sq  += longint'(e) * longint'(e);
      if (taken == 0) begin
        lo    = e;
        hi    = e;
        lo_at = '0;
        hi_at = '0;
      end else begin
        // strict compares keep the earlier of equal values
        if (e < lo) begin
          lo    = e;
          lo_at = vrs_pkg::idx_t'(taken);
        end
        if (e > hi) begin
          hi    = e;
          hi_at = vrs_pkg::idx_t'(taken);
        end
      end
      taken++;
    end
    if (closing) begin
      mean     = (taken != 0) ? run_sum / longint'(taken) : 0;
      w.min_v  = lo;
      w.max_v  = hi;
      w.min_i  = lo_at;
      w.max_i  = hi_at;
      w.mean_v = vrs_pkg::elem_t'(mean);
      w.norm_v = floor_root(run_sq);
      w.ovf    = spill;
      stats_due.push_back(w);
      outstanding++;
      clear_sums();
    end
  endtask

  // Result side first, then the input side, on every rising edge
  always @(posedge clk) begin
    stats_word_t got;
    stats_word_t want;
    if (!rst_n) begin
      clear_sums();
      stats_due.delete();
      outstanding = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_min_value, out_max_value, out_min_index, out_max_index,
               out_mean_value, out_norm_value, out_overflow};
        if (stats_due.size() == 0) begin
          flag_mismatch("result word with nothing expected");
        end else begin
          want = stats_due.pop_front();
          outstanding--;
          check_field("min_value", got.min_v, want.min_v);
          check_field("max_value", got.max_v, want.max_v);
          check_field("min_index", got.min_i, want.min_i);
          check_field("max_index", got.max_i, want.max_i);
          check_field("mean_value", got.mean_v, want.mean_v);
          check_field("norm_value", got.norm_v, want.norm_v);
          check_field("overflow", got.ovf, want.ovf);
        end
      end
      if (in_valid && in_ready) begin
        fold_element(in_element, in_last);
      end
    end
  end

endmodule

/* dv/vector_reduction_stats_top_tb.sv */
// Testbench top for vector_reduction_stats_top: clock, reset, element stimulus,
// receiver stalls and the verdict. Depends on vrs_pkg, the rtl and vrs_stats_checker.
module vector_reduction_stats_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 250000;
  localparam int SHORT_WORDS = 200;
  localparam int CALM_WORDS  = 60;
  localparam int DRAIN_WAIT  = 80;
  localparam int N_DIRECTED  = 21;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  vrs_pkg::elem_t in_element = '0;
  logic           in_last = 1'b0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  vrs_pkg::elem_t out_min_value;
  vrs_pkg::elem_t out_max_value;
  vrs_pkg::idx_t  out_min_index;
  vrs_pkg::idx_t  out_max_index;
  vrs_pkg::elem_t out_mean_value;
  vrs_pkg::norm_t out_norm_value;
  logic           out_overflow;
  int             fail_count;
  int             outstanding;

  // Idling controls
  bit calm = 1'b0;
  bit lazy_sender = 1'b1;
  int stall_left = 0;
  int cycles = 0;

  // Directed vectors: single extremes, ties, truncation of the mean, bit patterns
  vrs_pkg::elem_t dir_elem [N_DIRECTED] = '{
    16'h7fff, 16'h8000, 16'h0000,
    16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
    16'hffff, 16'hfffe,
    16'h0001, 16'h0002,
    16'h0100, 16'h0100, 16'h0100,
    16'hfffd, 16'h0007, 16'hfffd, 16'h0007, 16'h0000,
    16'h5555, 16'haaaa
  };
  bit dir_last [N_DIRECTED] = '{
    1'b1, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b1,
    1'b0, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b1
  };

  vector_reduction_stats_top dut (.*);
  vrs_stats_checker u_checker (.*);

  always #2 clk = ~clk;

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver stalls in random bursts
  always @(negedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Extremes and near-zero values often, so ties and limits come up
  function automatic vrs_pkg::elem_t pick_element();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3: return vrs_pkg::elem_t'($urandom_range(0, 8)) - vrs_pkg::elem_t'(4);
      default: return vrs_pkg::elem_t'($urandom());
    endcase
  endfunction

  // Offer one word from a falling edge and hold it until taken
  task automatic send_word(input vrs_pkg::elem_t e, input logic closing);
    int gap;
    if (!calm && lazy_sender && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_element <= e;
    in_last    <= closing;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int sent;
    int len;
    int extra;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < N_DIRECTED; k++) begin
      send_word(dir_elem[k], dir_last[k]);
    end

    // Hold off until the block has handed back everything
    in_valid <= 1'b0;
    wait_drained();
    @(negedge clk);

    // Full length of the most negative value puts mean and norm at their limits;
    // words past the limit are dropped and the last one still closes
    extra = $urandom_range(1, 6);
    for (int k = 0; k < vrs_pkg::MAX_LEN_DEF + extra; k++) begin
      send_word((k < vrs_pkg::MAX_LEN_DEF) ? 16'h8000 : pick_element(),
                k == vrs_pkg::MAX_LEN_DEF + extra - 1);
    end

    // Mostly short vectors with random content
    sent = 0;
    while (sent < SHORT_WORDS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      lazy_sender = ($urandom_range(0, 3) != 0);
      if (sent >= SHORT_WORDS - CALM_WORDS) calm = 1'b1;
      for (int k = 0; k < len; k++) begin
        send_word(pick_element(), k == len - 1);
      end
      sent += len;
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/vrs_pkg.sv
rtl/vrs_sub.sv
rtl/vrs_accum.sv
rtl/vrs_iter.sv
rtl/vector_reduction_stats_top.sv
dv/vrs_stats_checker.sv
dv/vector_reduction_stats_top_tb.sv
